>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the RTL. The enclosing module must
// provide clk and rst_n; checks are disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

>>> rtl/acsf_pkg.sv
// ----------------------------------------------------------------------------
// acsf_pkg
// Shared constants, types and helper functions for the ASCII command to
// SPI frame unit.
// ----------------------------------------------------------------------------
package acsf_pkg;

    // Message buffer geometry
    localparam int MAX_MESSAGE_LENGTH = 20;
    localparam int POS_W              = 5;
    localparam int CHARS_DEPTH        = 8;
    localparam int CHARS_IDX_W        = 3;
    localparam int FRAME_LEN          = 4;
    localparam int FRAME_IDX_W        = 2;
    localparam int COUNT_W            = 3;

    // Framing characters
    localparam logic [7:0] CH_START = 8'h40;   // '@'
    localparam logic [7:0] CH_END   = 8'h2A;   // '*'

    // SPI frame opcodes and register bases
    localparam logic [7:0] OP_WRITE  = 8'h64;
    localparam logic [7:0] OP_READ   = 8'h65;
    localparam logic [7:0] ADDR_FREQ = 8'h10;
    localparam logic [7:0] ADDR_DUTY = 8'h20;

    // Result status codes
    localparam logic [1:0] STATUS_FRAME    = 2'd0;
    localparam logic [1:0] STATUS_UNKNOWN  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef logic [7:0]                  char_t;
    typedef char_t [CHARS_DEPTH-1:0]     chars_t;
    typedef char_t [FRAME_LEN-1:0]       frame_t;

    typedef struct packed {
        logic   unknown;
        frame_t frame;
    } decode_t;

    // ASCII hex digit to nibble; anything else reads as zero
    function automatic logic [3:0] hex_val(input char_t c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 4'(c - 8'h37);
        end
        return v;
    endfunction

endpackage

>>> rtl/acsf_decode.sv
// ----------------------------------------------------------------------------
// acsf_decode
// Decodes the first eight message characters into a four-byte SPI frame,
// or flags the command as unknown.
// ----------------------------------------------------------------------------
module acsf_decode
    import acsf_pkg::*;
(
    input  chars_t  chars,
    output decode_t result
);

    localparam char_t CH_P  = 8'h70;  // 'p'
    localparam char_t CH_F  = 8'h66;  // 'f'
    localparam char_t CH_D  = 8'h64;  // 'd'
    localparam char_t CH_W  = 8'h77;  // 'w'
    localparam char_t CH_R  = 8'h72;  // 'r'
    localparam char_t CH_1  = 8'h31;  // '1'
    localparam char_t CH_4  = 8'h34;  // '4'

    logic       is_freq;
    logic       is_write;
    logic       cmd_ok;
    logic [1:0] chan;
    char_t      base;

    // Command syntax check
    assign is_freq  = (chars[1] == CH_F);
    assign is_write = (chars[2] == CH_W);
    assign cmd_ok   = (chars[0] == CH_P)
                   && (is_freq || chars[1] == CH_D)
                   && (is_write || chars[2] == CH_R)
                   && (chars[3] >= CH_1) && (chars[3] <= CH_4);

    // '1'..'4' map to channel 0..3 from the low two bits
    assign chan = chars[3][1:0] - 2'd1;
    assign base = is_freq ? ADDR_FREQ : ADDR_DUTY;

    // Frame assembly
    always_comb
    begin
        result.unknown  = !cmd_ok;
        result.frame[0] = is_write ? OP_WRITE : OP_READ;
        result.frame[1] = {base[7:2], chan};
        result.frame[2] = 8'h00;
        result.frame[3] = 8'h00;
        if (is_write && is_freq)
        begin
            result.frame[2] = {hex_val(chars[4]), hex_val(chars[5])};
            result.frame[3] = {hex_val(chars[6]), hex_val(chars[7])};
        end
        else if (is_write)
        begin
            result.frame[3] = {hex_val(chars[4]), hex_val(chars[5])};
        end
    end

endmodule

>>> rtl/ascii_command_to_spi_frame_unit.sv
// ----------------------------------------------------------------------------
// ascii_command_to_spi_frame_unit
// Parses an ASCII command byte stream and emits four-byte SPI frames or
// status results.
// ----------------------------------------------------------------------------
// Each received byte is registered, then processed against the message
// buffer. Start and data bytes that produce no result flow at one
// transaction per clock, even while a frame is still being sent. A
// terminator loads a four-byte frame (or a single unknown-command result)
// into the result buffer, and a data byte that fills the buffer loads an
// overflow result; the output port drains the result buffer one byte per
// cycle while out_stall is low, and the next result-producing byte waits
// for it. A result passes the input register, then the result buffer
// registers, before it reaches the output.
`include "assert_macros.svh"
module ascii_command_to_spi_frame_unit
    import acsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] spi_byte,
    output logic       frame_last,
    output logic [1:0] status
);

    // Input register
    logic             in_valid_reg;
    char_t            rx_byte_reg;

    // Message state
    chars_t           chars_reg, chars_next;
    logic [POS_W-1:0] write_pos_reg, write_pos_next;

    // Result buffer
    frame_t             frame_reg, frame_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [FRAME_IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]         status_reg, status_next;

    logic                   is_start;
    logic                   is_end;
    logic                   in_range;
    logic [CHARS_IDX_W-1:0] widx;
    logic [POS_W:0]         pos_inc;
    logic                   wraps;
    logic                   needs_results;
    logic                   out_accept;
    logic                   buf_free;
    logic                   advance;
    chars_t                 chars_view;
    decode_t                dec;

    // Byte classification
    assign is_start = (rx_byte_reg == CH_START);
    assign is_end   = (rx_byte_reg == CH_END);
    assign in_range = (write_pos_reg < POS_W'(CHARS_DEPTH));
    assign widx     = write_pos_reg[CHARS_IDX_W-1:0];
    assign pos_inc  = {1'b0, write_pos_reg} + (POS_W+1)'(1);
    assign wraps    = !is_start && !is_end && (pos_inc >= (POS_W+1)'(MAX_MESSAGE_LENGTH));
    assign needs_results = is_end || wraps;

    // Handshake
    assign out_valid  = (count_reg != '0);
    assign out_accept = out_valid && !out_stall;
    assign buf_free   = (count_reg == '0) || ((count_reg == COUNT_W'(1)) && out_accept);
    assign advance    = in_valid_reg && (!needs_results || buf_free);
    assign in_stall   = in_valid_reg && !advance;

    // Buffer as seen by the decoder: terminator zero written in place
    always_comb
    begin
        chars_view = chars_reg;
        if (is_end && in_range)
        begin
            chars_view[widx] = 8'h00;
        end
    end

    acsf_decode u_decode (
        .chars  (chars_view),
        .result (dec)
    );

    // Message state update
    always_comb
    begin
        chars_next     = chars_reg;
        write_pos_next = write_pos_reg;
        if (advance)
        begin
            if (is_start)
            begin
                write_pos_next = '0;
            end
            else if (is_end)
            begin
                chars_next = chars_view;
            end
            else
            begin
                if (in_range)
                begin
                    chars_next[widx] = rx_byte_reg;
                end
                write_pos_next = wraps ? '0 : pos_inc[POS_W-1:0];
            end
        end
    end

    // Result buffer load and drain
    always_comb
    begin
        frame_next  = frame_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        if (advance && needs_results)
        begin
            idx_next = '0;
            if (is_end && !dec.unknown)
            begin
                frame_next  = dec.frame;
                count_next  = COUNT_W'(FRAME_LEN);
                status_next = STATUS_FRAME;
            end
            else
            begin
                frame_next  = '0;
                count_next  = COUNT_W'(1);
                status_next = is_end ? STATUS_UNKNOWN : STATUS_OVERFLOW;
            end
        end
        else if (out_accept)
        begin
            count_next = count_reg - COUNT_W'(1);
            idx_next   = idx_reg + FRAME_IDX_W'(1);
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            chars_reg     <= '0;
            write_pos_reg <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            chars_reg     <= chars_next;
            write_pos_reg <= write_pos_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            rx_byte_reg <= rx_byte;
        end
        frame_reg  <= frame_next;
        status_reg <= status_next;
    end

    // Outputs
    assign spi_byte   = frame_reg[idx_reg];
    assign frame_last = (count_reg == COUNT_W'(1));
    assign status     = status_reg;

    // Checks
    `ASSERT_NEVER(a_count_range, count_reg > COUNT_W'(FRAME_LEN), "result count out of range")
    `ASSERT_NEVER(a_pos_range, write_pos_reg >= POS_W'(MAX_MESSAGE_LENGTH), "write position past max")
    `ASSERT_CLK(a_status_single, out_valid && status != STATUS_FRAME |-> frame_last, "status not last")
    `ASSERT_CLK(a_busy_stall, in_valid_reg && needs_results && count_reg > COUNT_W'(1) |-> in_stall, "result overrun")

endmodule

>>> verif/tb_ascii_command_to_spi_frame_unit.sv
// ----------------------------------------------------------------------------
// tb_ascii_command_to_spi_frame_unit
// Self-checking testbench for the ASCII command to SPI frame unit. A short
// directed table covers the first decode after reset, read and write frames,
// stale buffer contents and extreme byte values. Random command streams,
// noise and runaway messages follow. Every result byte is checked against the
// table or a local model of the parser while both ports idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ascii_command_to_spi_frame_unit;
    import acsf_pkg::*;

    localparam int RANDOM_CHARS = 235;
    localparam int IDLE_LIMIT   = 1000;
    localparam int HOLDOFF_LEN  = 150;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] spi;
        logic       last;
        logic [1:0] st;
    } spi_result_t;

    typedef struct packed {
        logic [7:0]             ch;
        logic                   typed;
        logic [2:0]             n;
        spi_result_t [3:0]      res;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] spi_byte;
    logic       frame_last;
    logic [1:0] status;

    // Local copy of the parser state
    logic [7:0]  msg_chars [8];
    logic [4:0]  wr_pos;

    spi_result_t spi_expected_q [$];
    dir_row_t    dir_rows [$];
    logic [7:0]  rand_chars [$];
    int          err_count = 0;
    int          burst_left = 0;
    int unsigned chars_sent = 0;

    ascii_command_to_spi_frame_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .spi_byte   (spi_byte),
        .frame_last (frame_last),
        .status     (status)
    );

    always #5 clk = ~clk;

    // ASCII hex digit to nibble, anything else is zero
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= "0" && c <= "9")
        begin
            v = 4'(c - "0");
        end
        else if (c >= "a" && c <= "f")
        begin
            v = 4'(c - "a" + 8'd10);
        end
        else if (c >= "A" && c <= "F")
        begin
            v = 4'(c - "A" + 8'd10);
        end
        return v;
    endfunction

    function automatic spi_result_t mk_res(input logic [7:0] b, input logic l,
                                           input logic [1:0] s);
        spi_result_t r;
        r.spi  = b;
        r.last = l;
        r.st   = s;
        return r;
    endfunction

    function automatic spi_result_t [3:0] mk_frame(input logic [7:0] b0, input logic [7:0] b1,
                                                   input logic [7:0] b2, input logic [7:0] b3);
        spi_result_t [3:0] f;
        f[0] = mk_res(b0, 1'b0, STATUS_FRAME);
        f[1] = mk_res(b1, 1'b0, STATUS_FRAME);
        f[2] = mk_res(b2, 1'b0, STATUS_FRAME);
        f[3] = mk_res(b3, 1'b1, STATUS_FRAME);
        return f;
    endfunction

    // Any byte except the start and end markers
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (c == CH_START || c == CH_END);
        return c;
    endfunction

    // Decode the first eight buffered characters into a frame or unknown status
    function automatic void decode_message(output spi_result_t [3:0] res, output int n);
        logic        is_freq;
        logic        is_write;
        logic [7:0]  chan;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [15:0] word;
        res = '0;
        if (msg_chars[0] != "p" || (msg_chars[1] != "f" && msg_chars[1] != "d") ||
            (msg_chars[2] != "w" && msg_chars[2] != "r") ||
            msg_chars[3] < "1" || msg_chars[3] > "4")
        begin
            res[0] = mk_res(8'h00, 1'b1, STATUS_UNKNOWN);
            n = 1;
        end
        else
        begin
            is_freq  = (msg_chars[1] == "f");
            is_write = (msg_chars[2] == "w");
            chan     = msg_chars[3] - "1";
            b2       = 8'h00;
            b3       = 8'h00;
            if (is_write && is_freq)
            begin
                word = {nibble_of(msg_chars[4]), nibble_of(msg_chars[5]),
                        nibble_of(msg_chars[6]), nibble_of(msg_chars[7])};
                b2   = word[15:8];
                b3   = word[7:0];
            end
            else if (is_write)
            begin
                b3 = {nibble_of(msg_chars[4]), nibble_of(msg_chars[5])};
            end
            res = mk_frame(is_write ? OP_WRITE : OP_READ,
                           (is_freq ? ADDR_FREQ : ADDR_DUTY) + chan, b2, b3);
            n = 4;
        end
    endfunction

    // Advance the parser state by one received character
    function automatic void predict_spi_results(input logic [7:0] ch,
                                                output spi_result_t [3:0] res, output int n);
        int pos;
        pos = int'(wr_pos);
        res = '0;
        n   = 0;
        if (ch == CH_START)
        begin
            wr_pos = '0;
        end
        else if (ch == CH_END)
        begin
            if (pos < 8)
            begin
                msg_chars[pos] = 8'h00;
            end
            decode_message(res, n);
        end
        else
        begin
            if (pos < 8)
            begin
                msg_chars[pos] = ch;
            end
            pos = pos + 1;
            if (pos >= MAX_MESSAGE_LENGTH)
            begin
                wr_pos = '0;
                res[0] = mk_res(8'h00, 1'b1, STATUS_OVERFLOW);
                n      = 1;
            end
            else
            begin
                wr_pos = 5'(pos);
            end
        end
    endfunction

    // Offer one character, wait for acceptance, record what it should produce
    task automatic drive_char(input logic [7:0] ch, input logic typed, input logic [2:0] n_typed,
                              input spi_result_t [3:0] typed_res);
        spi_result_t [3:0] pred;
        int                n_pred;
        in_valid <= 1'b1;
        rx_byte  <= ch;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        chars_sent++;
        predict_spi_results(ch, pred, n_pred);
        if (typed)
        begin
            pred   = typed_res;
            n_pred = int'(n_typed);
        end
        for (int i = 0; i < n_pred; i++)
        begin
            spi_expected_q.push_back(pred[i]);
        end
        // Burst bookkeeping: drop in_valid for a random gap once a burst runs out
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(30, 60))
                                                     : int'($urandom_range(0, 10));
        end
    endtask

    // Stop offering and let every outstanding result come out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (spi_expected_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic add_row(input logic [7:0] ch);
        dir_row_t r;
        r       = '0;
        r.ch    = ch;
        dir_rows.push_back(r);
    endtask

    task automatic add_checked(input logic [7:0] ch, input logic [2:0] n,
                               input spi_result_t [3:0] res);
        dir_row_t r;
        r.ch    = ch;
        r.typed = 1'b1;
        r.n     = n;
        r.res   = res;
        dir_rows.push_back(r);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        spi_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (spi_expected_q.size() == 0)
            begin
                $error("unexpected result: spi_byte %02h frame_last %0d status %0d",
                       spi_byte, frame_last, status);
                err_count++;
            end
            else
            begin
                want = spi_expected_q.pop_front();
                if (spi_byte !== want.spi)
                begin
                    $error("spi_byte: expected %02h, actual %02h", want.spi, spi_byte);
                    err_count++;
                end
                if (frame_last !== want.last)
                begin
                    $error("frame_last: expected %0d, actual %0d", want.last, frame_last);
                    err_count++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, actual %0d", want.st, status);
                    err_count++;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off once traffic is flowing
    initial
    begin : receiver
        int  mode;
        int  span;
        bit  held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && chars_sent >= 60)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLDOFF_LEN) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 60);
            for (int k = 0; k < span; k++)
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 30);
                    2: out_stall <= ($urandom_range(0, 99) < 70);
                    default: out_stall <= k[0];
                endcase
                @(posedge clk);
            end
        end
    end

    // Watchdog on cycles without any transaction
    initial
    begin : watchdog
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        spi_result_t [3:0] unk;
        string             hex_digits;
        int                kind;
        int                len;
        int                half;
        logic [7:0]        c;

        for (int i = 0; i < 8; i++)
        begin
            msg_chars[i] = 8'h00;
        end
        wr_pos     = '0;
        hex_digits = "0123456789abcdefABCDEF";
        unk        = '0;
        unk[0]     = mk_res(8'h00, 1'b1, STATUS_UNKNOWN);

        // Directed table
        // terminator right after reset decodes an all-zero buffer
        add_checked(CH_END, 3'd1, unk);
        // read frame without a start marker, position still at zero
        add_row("p"); add_row("f"); add_row("r"); add_row("1");
        add_checked(CH_END, 3'd4, mk_frame(OP_READ, ADDR_FREQ, 8'h00, 8'h00));
        // duty write, mixed-case hex, highest channel
        add_row(CH_START); add_row("p"); add_row("d"); add_row("w"); add_row("4");
        add_row("F"); add_row("f");
        add_checked(CH_END, 3'd4, mk_frame(OP_WRITE, ADDR_DUTY + 8'd3, 8'h00, 8'hFF));
        // short frequency write: value digits are stale and terminator zero
        add_row(CH_START); add_row("p"); add_row("f"); add_row("w"); add_row("2");
        add_row(CH_END);
        // extreme byte values
        add_row(CH_START); add_row(8'hFF); add_row(8'h00);
        add_checked(CH_END, 3'd1, unk);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            drive_char(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].n, dir_rows[i].res);
        end
        drain_results();

        // Random streams: mostly commands, some noise, runaway messages, bare terminators
        while (rand_chars.size() < RANDOM_CHARS)
        begin
            kind = (rand_chars.size() == 0) ? 70 : int'($urandom_range(0, 99));
            if (kind < 65)
            begin
                if ($urandom_range(0, 9) != 0)
                begin
                    rand_chars.push_back(CH_START);
                end
                rand_chars.push_back(($urandom_range(0, 19) != 0) ? 8'h70 : plain_char());
                rand_chars.push_back(($urandom_range(0, 19) == 0) ? plain_char() :
                                     ($urandom_range(0, 1) != 0) ? 8'h66 : 8'h64);
                rand_chars.push_back(($urandom_range(0, 19) == 0) ? plain_char() :
                                     ($urandom_range(0, 1) != 0) ? 8'h77 : 8'h72);
                case ($urandom_range(0, 11))
                    0: rand_chars.push_back("0");
                    1: rand_chars.push_back("5");
                    2: rand_chars.push_back(plain_char());
                    default: rand_chars.push_back(8'("1" + $urandom_range(0, 3)));
                endcase
                len = $urandom_range(0, 6);
                for (int k = 0; k < len; k++)
                begin
                    c = ($urandom_range(0, 99) < 85) ?
                        hex_digits[$urandom_range(0, hex_digits.len() - 1)] : plain_char();
                    rand_chars.push_back(c);
                end
                rand_chars.push_back(CH_END);
            end
            else if (kind < 80)
            begin
                // runaway message of 18 to 30 plain characters, which can wrap the buffer
                len = $urandom_range(18, 30);
                for (int k = 0; k < len; k++)
                begin
                    rand_chars.push_back(plain_char());
                end
                if ($urandom_range(0, 1) != 0)
                begin
                    rand_chars.push_back(CH_END);
                end
            end
            else if (kind < 95)
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                begin
                    rand_chars.push_back(8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                begin
                    rand_chars.push_back(CH_END);
                end
            end
        end

        half = $urandom_range(rand_chars.size() / 3, 2 * rand_chars.size() / 3);
        foreach (rand_chars[i])
        begin
            if (i == half)
            begin
                drain_results();
            end
            drive_char(rand_chars[i], 1'b0, 3'd0, '0);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && spi_expected_q.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
